### rtl/xeu_pkg.sv
// shared types and constants for the execute unit
`default_nettype none
package xeu_pkg;
	typedef enum logic [2:0] {
		FN_MOV_RR = 3'd0,
		FN_ADD_RR = 3'd1,
		FN_CALL   = 3'd2,
		FN_PUSH   = 3'd3,
		FN_MOV_RM = 3'd4,
		FN_MOV_MR = 3'd5,
		FN_RET    = 3'd6,
		FN_POP    = 3'd7
	} func_t;

	localparam logic [3:0] MD_IMM       = 4'd1;
	localparam logic [3:0] MD_REG       = 4'd2;
	localparam logic [3:0] MD_M_IMM     = 4'd3;
	localparam logic [3:0] MD_M_R1      = 4'd4;
	localparam logic [3:0] MD_M_IMM_R1  = 4'd5;
	localparam logic [3:0] MD_M_R1R2    = 4'd6;
	localparam logic [3:0] MD_M_IMM_R12 = 4'd7;
	localparam logic [3:0] MD_M_SC      = 4'd8;
	localparam logic [3:0] MD_M_IMM_SC  = 4'd9;
	localparam logic [3:0] MD_M_R1_SC   = 4'd10;
	localparam logic [3:0] MD_M_ALL     = 4'd11;

	localparam logic [63:0] WORD_BYTES = 64'd8;

	// data memory depth, a power of two so the word index is a bit slice
	localparam int MEMORY_WORDS = 4096;

	localparam logic [0:0] CFG_START_PC = 1'b0;
	localparam logic [0:0] CFG_START_SP = 1'b1;

	typedef struct packed {
		logic [3:0]  mode;
		logic [63:0] imm;
		logic [3:0]  base;
		logic [3:0]  index;
		logic [3:0]  scale;
	} opnd_t;

	typedef struct packed {
		func_t func;
		opnd_t src;
		opnd_t dst;
	} instr_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [63:0] stack_pointer;
		logic        reg_written;
		logic [3:0]  reg_target;
		logic [63:0] reg_result;
		logic        mem_written;
		logic [63:0] mem_address;
		logic [63:0] mem_result;
	} result_t;
endpackage
`default_nettype wire

### rtl/xeu_front.sv
// input stage and instruction queue feeding the execute stage
`default_nettype none
module xeu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire xeu_pkg::instr_t in_item,
	output logic                q_valid,
	output xeu_pkg::instr_t     q_item,
	input  wire logic           q_take
);
	import xeu_pkg::*;

	instr_t     slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= ~wr_q;
			if (q_take && q_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(q_take && q_valid);
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	ap_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("take from empty queue");
	ap_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_take) |=> full) else $error("full dropped without take");
endmodule
`default_nettype wire

### rtl/xeu_back.sv
// execute stage: operand decode, register file, data memory, result queue
`default_nettype none
module xeu_back #(
	parameter int REGISTER_COUNT     = 16,
	parameter int INSTRUCTION_STRIDE = 32,
	parameter int STACK_REGISTER     = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [0:0]      cfg_idx,
	input  wire logic [63:0]     cfg_data,
	input  wire logic            q_valid,
	input  wire xeu_pkg::instr_t q_item,
	output logic                 q_take,
	output logic                 empty,
	input  wire logic            pop,
	output xeu_pkg::result_t     res
);
	import xeu_pkg::*;

	localparam int RW = $clog2(REGISTER_COUNT);
	localparam int MW = $clog2(MEMORY_WORDS);
	localparam int SP = STACK_REGISTER % REGISTER_COUNT;
	localparam logic [RW-1:0] SP_IDX = RW'(SP);
	localparam logic [63:0] STRIDE = 64'(INSTRUCTION_STRIDE);

	logic [63:0] rf_q [REGISTER_COUNT];
	logic [63:0] pc_q;
	logic [63:0] mem [MEMORY_WORDS];

	// memory cleared word by word after reset
	logic          clr_q;
	logic [MW:0]   clr_cnt_q;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MEM} st_t;
	st_t st_q;

	instr_t      ins_s1;
	logic [63:0] srcv_s1, dstv_s1, sreg_v_s1, dreg_v_s1, sp_s1, next_s1;
	logic [MW-1:0] rd_w_s1;
	logic [63:0] rdata_s2;

	logic        out_v_q;
	result_t     out_q;

	// register index modulo the register count by one subtraction, exact while the count is at least 8; index is below 16
	function automatic logic [RW-1:0] ridx(logic [3:0] i);
		logic [4:0] w;
		w = {1'b0, i};
		if (w >= 5'(REGISTER_COUNT))
			w = w - 5'(REGISTER_COUNT);
		return RW'(w);
	endfunction

	function automatic logic [63:0] opval(opnd_t o, logic [63:0] r1, logic [63:0] r2);
		logic [63:0] sc;
		sc = r2 * 64'(o.scale);
		unique case (o.mode)
			MD_IMM, MD_M_IMM: return o.imm;
			MD_REG, MD_M_R1:  return r1;
			MD_M_IMM_R1:      return o.imm + r1;
			MD_M_R1R2:        return r1 + r2;
			MD_M_IMM_R12:     return o.imm + r1 + r2;
			MD_M_SC:          return sc;
			MD_M_IMM_SC:      return o.imm + sc;
			MD_M_R1_SC:       return r1 + sc;
			MD_M_ALL:         return o.imm + r1 + sc;
			default:          return 64'd0;
		endcase
	endfunction

	function automatic logic [MW-1:0] word_of(logic [63:0] a);
		return a[MW+2:3];
	endfunction

	logic [63:0] sp_now;
	assign sp_now = rf_q[SP_IDX];

	assign q_take = (st_q == S_IDLE) && q_valid && !clr_q && (!out_v_q || pop);
	assign empty  = !out_v_q;
	assign res    = out_q;

	// stage-one operand decode, one item at a time
	always_ff @(posedge clk) begin
		if (q_take) begin
			ins_s1    <= q_item;
			srcv_s1   <= opval(q_item.src, rf_q[ridx(q_item.src.base)],
				rf_q[ridx(q_item.src.index)]);
			dstv_s1   <= opval(q_item.dst, rf_q[ridx(q_item.dst.base)],
				rf_q[ridx(q_item.dst.index)]);
			sreg_v_s1 <= rf_q[ridx(q_item.src.base)];
			dreg_v_s1 <= rf_q[ridx(q_item.dst.base)];
			sp_s1     <= sp_now;
			next_s1   <= pc_q + STRIDE;
		end
	end

	// read address chosen from decoded values
	always_comb begin
		unique case (ins_s1.func)
			FN_MOV_MR: rd_w_s1 = word_of(srcv_s1);
			default:   rd_w_s1 = word_of(sp_s1);
		endcase
	end

	logic          we;
	logic [MW-1:0] wa;
	logic [63:0]   wd;
	always_comb begin
		we = 1'b0;
		wa = clr_cnt_q[MW-1:0];
		wd = 64'd0;
		if (clr_q) begin
			we = 1'b1;
		end else if (st_q == S_EXEC) begin
			unique case (ins_s1.func)
				FN_CALL: begin
					we = 1'b1; wa = word_of(sp_s1 - WORD_BYTES); wd = next_s1;
				end
				FN_PUSH: begin
					we = 1'b1; wa = word_of(sp_s1 - WORD_BYTES); wd = sreg_v_s1;
				end
				FN_MOV_RM: begin
					we = 1'b1; wa = word_of(dstv_s1); wd = sreg_v_s1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_s2 <= mem[rd_w_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			out_v_q   <= 1'b0;
			pc_q      <= 64'd0;
			for (int i = 0; i < REGISTER_COUNT; i++)
				rf_q[i] <= 64'd0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + (MW+1)'(1);
				if (clr_cnt_q == (MW+1)'(MEMORY_WORDS - 1))
					clr_q <= 1'b0;
			end
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_take) st_q <= S_EXEC;
				S_EXEC: begin
					priority if (ins_s1.func == FN_MOV_MR || ins_s1.func == FN_RET ||
							ins_s1.func == FN_POP) begin
						st_q <= S_MEM;
					end else begin
						st_q <= S_IDLE;
						out_v_q <= 1'b1;
						out_q.mem_result  <= wd;
						out_q.mem_written <= we;
						out_q.mem_address <= {{(61-MW){1'b0}}, wa, 3'b000};
						out_q.next_pc     <= next_s1;
						out_q.reg_written <= 1'b0;
						out_q.reg_target  <= 4'd0;
						out_q.reg_result  <= 64'd0;
						out_q.stack_pointer <= sp_s1;
						pc_q <= next_s1;
						unique case (ins_s1.func)
							FN_MOV_RR, FN_ADD_RR: begin
								out_q.reg_written <= 1'b1;
								out_q.reg_target  <= 4'(ridx(ins_s1.dst.base));
								out_q.reg_result  <= (ins_s1.func == FN_ADD_RR) ?
									dreg_v_s1 + sreg_v_s1 : sreg_v_s1;
								rf_q[ridx(ins_s1.dst.base)] <=
									(ins_s1.func == FN_ADD_RR) ?
									dreg_v_s1 + sreg_v_s1 : sreg_v_s1;
								if (ridx(ins_s1.dst.base) == SP_IDX)
									out_q.stack_pointer <= (ins_s1.func == FN_ADD_RR) ?
										dreg_v_s1 + sreg_v_s1 : sreg_v_s1;
							end
							FN_CALL: begin
								rf_q[SP_IDX] <= sp_s1 - WORD_BYTES;
								out_q.stack_pointer <= sp_s1 - WORD_BYTES;
								out_q.next_pc <= srcv_s1;
								pc_q <= srcv_s1;
							end
							FN_PUSH: begin
								rf_q[SP_IDX] <= sp_s1 - WORD_BYTES;
								out_q.stack_pointer <= sp_s1 - WORD_BYTES;
							end
							default: ;
						endcase
					end
				end
				S_MEM: begin
					st_q    <= S_IDLE;
					out_v_q <= 1'b1;
					out_q.mem_written <= 1'b0;
					out_q.mem_result  <= rdata_s2;
					out_q.mem_address <= {{(61-MW){1'b0}}, rd_w_s1, 3'b000};
					out_q.next_pc     <= next_s1;
					out_q.stack_pointer <= sp_s1;
					out_q.reg_written <= 1'b0;
					out_q.reg_target  <= 4'd0;
					out_q.reg_result  <= 64'd0;
					pc_q <= next_s1;
					unique case (ins_s1.func)
						FN_MOV_MR: begin
							out_q.reg_written <= 1'b1;
							out_q.reg_target  <= 4'(ridx(ins_s1.dst.base));
							out_q.reg_result  <= rdata_s2;
							rf_q[ridx(ins_s1.dst.base)] <= rdata_s2;
							if (ridx(ins_s1.dst.base) == SP_IDX)
								out_q.stack_pointer <= rdata_s2;
						end
						FN_RET: begin
							rf_q[SP_IDX] <= sp_s1 + WORD_BYTES;
							out_q.stack_pointer <= sp_s1 + WORD_BYTES;
							out_q.next_pc <= rdata_s2;
							pc_q <= rdata_s2;
						end
						default: begin
							// popped value wins over the increment
							out_q.reg_written <= 1'b1;
							out_q.reg_target  <= 4'(ridx(ins_s1.src.base));
							out_q.reg_result  <= rdata_s2;
							rf_q[SP_IDX] <= sp_s1 + WORD_BYTES;
							out_q.stack_pointer <= (ridx(ins_s1.src.base) == SP_IDX) ?
								rdata_s2 : sp_s1 + WORD_BYTES;
							rf_q[ridx(ins_s1.src.base)] <= rdata_s2;
						end
					endcase
				end
				default: st_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				if (cfg_idx == CFG_START_PC)
					pc_q <= cfg_data;
				else
					rf_q[SP_IDX] <= cfg_data;
			end
		end
	end

	ap_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !q_take) else $error("item taken during clear");
	ap_one: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !q_take) else $error("second item while busy");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |=> out_v_q) else $error("result lost");
endmodule
`default_nettype wire

### rtl/x86_subset_execute_unit.sv
// x86 subset execute unit: accepts pre-decoded instructions and reports effects
// channels: instruction queue in (push/full), result queue out (empty/pop),
// plus a write-only config port (cfg_we, cfg_idx, cfg_data):
// index 0 loads the pc, index 1 loads the stack register.
// an item passes a two-entry front queue, then the execute stage decodes
// operands into registers and executes from them in S_EXEC; loads (mov_mr,
// ret and pop) pass a further S_MEM state for the registered memory read.
// the execute stage takes a new item only from S_IDLE, after the last one is
// done, a limit set by the register file and memory dependency between
// consecutive instructions.
// the result register holds one item; while it waits no instruction leaves
// the front queue, which then fills and raises full.
// after reset the data memory is cleared one word a cycle and no item
// leaves the front queue meanwhile; config writes are accepted throughout.
`default_nettype none
module x86_subset_execute_unit #(
	parameter int REGISTER_COUNT     = 16,
	parameter int INSTRUCTION_STRIDE = 32,
	parameter int STACK_REGISTER     = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  func,
	input  wire logic [3:0]  src_mode,
	input  wire logic [63:0] src_imm,
	input  wire logic [3:0]  src_base,
	input  wire logic [3:0]  src_index,
	input  wire logic [3:0]  src_scale,
	input  wire logic [3:0]  dst_mode,
	input  wire logic [63:0] dst_imm,
	input  wire logic [3:0]  dst_base,
	input  wire logic [3:0]  dst_index,
	input  wire logic [3:0]  dst_scale,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      next_pc,
	output logic [63:0]      stack_pointer,
	output logic             reg_written,
	output logic [3:0]       reg_target,
	output logic [63:0]      reg_result,
	output logic             mem_written,
	output logic [63:0]      mem_address,
	output logic [63:0]      mem_result
);
	import xeu_pkg::*;

	instr_t  in_item, q_item;
	logic    q_valid, q_take;
	result_t res;

	assign in_item.func = func_t'(func);
	assign in_item.src  = '{src_mode, src_imm, src_base, src_index, src_scale};
	assign in_item.dst  = '{dst_mode, dst_imm, dst_base, dst_index, dst_scale};

	xeu_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	xeu_back #(
		.REGISTER_COUNT(REGISTER_COUNT),
		.INSTRUCTION_STRIDE(INSTRUCTION_STRIDE), .STACK_REGISTER(STACK_REGISTER)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
		.empty(empty), .pop(pop), .res(res)
	);

	assign next_pc       = res.next_pc;
	assign stack_pointer = res.stack_pointer;
	assign reg_written   = res.reg_written;
	assign reg_target    = res.reg_target;
	assign reg_result    = res.reg_result;
	assign mem_written   = res.mem_written;
	assign mem_address   = res.mem_address;
	assign mem_result    = res.mem_result;
endmodule
`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the x86 subset execute unit
module tb_top;
	import xeu_pkg::*;

	localparam int NREG = 16;
	localparam int NWORDS = 4096;
	localparam int STRIDE = 32;
	localparam int SP_REG = 4;
	localparam int MAX_CYCLES = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [2:0] func = '0;
	logic [3:0] src_mode = '0, src_base = '0, src_index = '0, src_scale = '0;
	logic [3:0] dst_mode = '0, dst_base = '0, dst_index = '0, dst_scale = '0;
	logic [63:0] src_imm = '0, dst_imm = '0;
	logic empty;
	logic pop = 1'b0;
	logic [63:0] next_pc, stack_pointer, reg_result, mem_address, mem_result;
	logic reg_written, mem_written;
	logic [3:0] reg_target;

	x86_subset_execute_unit dut (.*);

	initial forever #2 clk = ~clk;

	// architectural copy of the unit
	logic [63:0] arch_regs [NREG];
	logic [63:0] arch_pc;
	logic [63:0] arch_mem [NWORDS];
	result_t effects_q[$];

	int send_idle_pct = 0;
	int take_idle_pct = 0;
	bit take_hold = 1'b0;
	int mismatches = 0;
	longint unsigned cycles = 0;

	function automatic logic [63:0] opnd_val(opnd_t o);
		logic [63:0] r1, r2, sc;
		r1 = arch_regs[o.base];
		r2 = arch_regs[o.index];
		sc = r2 * {60'd0, o.scale};
		case (o.mode)
			MD_IMM, MD_M_IMM: return o.imm;
			MD_REG, MD_M_R1: return r1;
			MD_M_IMM_R1: return o.imm + r1;
			MD_M_R1R2: return r1 + r2;
			MD_M_IMM_R12: return o.imm + r1 + r2;
			MD_M_SC: return sc;
			MD_M_IMM_SC: return o.imm + sc;
			MD_M_R1_SC: return r1 + sc;
			MD_M_ALL: return o.imm + r1 + sc;
			default: return 64'd0;
		endcase
	endfunction

	function automatic result_t execute_instr(instr_t in);
		result_t r;
		logic [63:0] sv, dv, sp, nxt;
		logic [11:0] w;
		sv = opnd_val(in.src);
		dv = opnd_val(in.dst);
		r = '0;
		nxt = arch_pc + 64'(STRIDE);
		sp = arch_regs[SP_REG];
		case (in.func)
			FN_MOV_RR: begin
				r.reg_written = 1; r.reg_target = in.dst.base;
				r.reg_result = arch_regs[in.src.base];
			end
			FN_ADD_RR: begin
				r.reg_written = 1; r.reg_target = in.dst.base;
				r.reg_result = arch_regs[in.dst.base] + arch_regs[in.src.base];
			end
			FN_CALL: begin
				sp -= WORD_BYTES; w = sp[14:3];
				r.mem_written = 1; r.mem_address = {49'd0, w, 3'd0}; r.mem_result = nxt;
				arch_mem[w] = nxt; nxt = sv;
			end
			FN_PUSH: begin
				r.mem_result = arch_regs[in.src.base];
				sp -= WORD_BYTES; w = sp[14:3];
				r.mem_written = 1; r.mem_address = {49'd0, w, 3'd0};
				arch_mem[w] = r.mem_result;
			end
			FN_MOV_RM: begin
				w = dv[14:3];
				r.mem_written = 1; r.mem_address = {49'd0, w, 3'd0};
				r.mem_result = arch_regs[in.src.base];
				arch_mem[w] = r.mem_result;
			end
			FN_MOV_MR: begin
				w = sv[14:3];
				r.mem_address = {49'd0, w, 3'd0}; r.mem_result = arch_mem[w];
				r.reg_written = 1; r.reg_target = in.dst.base; r.reg_result = r.mem_result;
			end
			FN_RET: begin
				w = sp[14:3];
				r.mem_address = {49'd0, w, 3'd0}; r.mem_result = arch_mem[w];
				sp += WORD_BYTES; nxt = r.mem_result;
			end
			default: begin
				w = sp[14:3];
				r.mem_address = {49'd0, w, 3'd0}; r.mem_result = arch_mem[w];
				sp += WORD_BYTES;
				r.reg_written = 1; r.reg_target = in.src.base; r.reg_result = r.mem_result;
			end
		endcase
		if (in.func inside {FN_CALL, FN_PUSH, FN_RET, FN_POP}) arch_regs[SP_REG] = sp;
		if (r.reg_written) arch_regs[r.reg_target] = r.reg_result;
		arch_pc = nxt;
		r.next_pc = arch_pc;
		r.stack_pointer = arch_regs[SP_REG];
		return r;
	endfunction

	// push stays high after an accept so back-to-back items need no gap
	task automatic send_instr(instr_t in);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		func <= in.func;
		src_mode <= in.src.mode; src_imm <= in.src.imm; src_base <= in.src.base;
		src_index <= in.src.index; src_scale <= in.src.scale;
		dst_mode <= in.dst.mode; dst_imm <= in.dst.imm; dst_base <= in.dst.base;
		dst_index <= in.dst.index; dst_scale <= in.dst.scale;
		do @(posedge clk); while (full);
		effects_q.push_back(execute_instr(in));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (effects_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(logic [0:0] idx, logic [63:0] val);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_START_PC) arch_pc = val;
		else arch_regs[SP_REG] = val;
	endtask

	function automatic opnd_t rand_opnd(bit wild);
		opnd_t o;
		o.mode = wild ? 4'($urandom) : 4'($urandom_range(11));
		o.imm = $urandom_range(3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(511) * 8);
		o.base = 4'($urandom); o.index = 4'($urandom);
		o.scale = wild ? 4'($urandom) : 4'(1 << $urandom_range(3));
		return o;
	endfunction

	function automatic instr_t rand_instr(bit wild);
		instr_t in;
		in.func = func_t'($urandom_range(7));
		in.src = rand_opnd(wild);
		in.dst = rand_opnd(wild);
		// keep the stack register mostly intact so push/pop pairs reuse memory
		if (!wild && in.func inside {FN_MOV_RR, FN_ADD_RR, FN_MOV_MR} && in.dst.base == SP_REG)
			in.dst.base = 4'(SP_REG + 1);
		return in;
	endfunction

	task automatic test_directed();
		instr_t in;
		for (int m = 0; m < 16; m++) begin
			in = '0;
			in.func = FN_MOV_RM;
			in.src.base = 4'(m); in.dst.mode = 4'(m);
			in.dst.imm = m[0] ? 64'hFFFF_FFFF_FFFF_FFF8 : 64'h7FFF_FFFF_FFFF_FFFF;
			in.dst.base = 4'(15 - m); in.dst.index = 4'(m); in.dst.scale = 4'(m);
			send_instr(in);
		end
		in = '0; in.src.base = 4'(SP_REG);
		in.func = FN_PUSH; send_instr(in);
		in.func = FN_POP; send_instr(in);
		in.func = FN_CALL; in.src.mode = MD_IMM; in.src.imm = 64'h8000_0000_0000_0000;
		send_instr(in);
		in.func = FN_RET; send_instr(in);
		in.func = FN_MOV_MR; in.src.mode = MD_M_IMM; in.src.imm = '1; in.dst.base = 4'd15;
		send_instr(in);
		in.func = FN_ADD_RR; in.src.base = 4'd15; in.dst.base = 4'd15; send_instr(in);
		in.func = FN_MOV_RR; in.dst.base = 4'd0; send_instr(in);
		drain();
	endtask

	task automatic test_random(int n, int sidle, int tidle);
		send_idle_pct = sidle; take_idle_pct = tidle;
		for (int i = 0; i < n; i++) send_instr(rand_instr($urandom_range(9) == 0));
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0; take_idle_pct = 0;
		take_hold = 1'b1;
		fork
			begin
				int k;
				for (k = 0; k < 200 && take_hold; k++) @(posedge clk);
				take_hold = 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++) send_instr(rand_instr(0));
		take_hold = 1'b0;
		drain();
	endtask

	// result checker and random stall on the output side
	always @(posedge clk) begin
		result_t exp_r, got;
		if (pop && !empty) begin
			got = '{next_pc, stack_pointer, reg_written, reg_target, reg_result,
				mem_written, mem_address, mem_result};
			if (effects_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %p", got);
			end else begin
				exp_r = effects_q.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
		pop <= !take_hold && !(take_idle_pct > 0 && $urandom_range(99) < take_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("[x86_subset_execute_unit] ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NREG; i++) arch_regs[i] = '0;
		for (int i = 0; i < NWORDS; i++) arch_mem[i] = '0;
		arch_pc = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(CFG_START_PC, '1);
		write_cfg(CFG_START_SP, 64'h0);
		test_directed();
		write_cfg(CFG_START_PC, 64'h0);
		write_cfg(CFG_START_SP, '1);
		test_random(350, 26, 62);
		test_backpressure();
		write_cfg(CFG_START_PC, {$urandom, $urandom});
		write_cfg(CFG_START_SP, 64'h8000);
		test_random(350, 62, 26);
		write_cfg(CFG_START_SP, {$urandom, $urandom});
		test_random(330, 0, 0);
		if (mismatches == 0 && effects_q.size() == 0)
			$display("[x86_subset_execute_unit] OK");
		else
			$display("[x86_subset_execute_unit] ERROR");
		$finish;
	end
endmodule
